// ===== rtl/resp_array_record_parser_unit_assert.svh =====
// Assertion macros for the RESP array record parser.
// Takes no other file; included by modules that carry assertions.
`ifndef RESP_ARRAY_RECORD_PARSER_UNIT_ASSERT_SVH
`define RESP_ARRAY_RECORD_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RARP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RARP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rarp_pkg.sv =====
// Types and constants of the RESP array record parser.
// No dependencies; used by resp_array_record_parser_unit.
`timescale 1ns / 1ps
`default_nettype none

package rarp_pkg;

   // parse phases
   localparam logic [2:0] PH_STAR    = 3'd0;
   localparam logic [2:0] PH_CNT_DIG = 3'd1;
   localparam logic [2:0] PH_CNT_LF  = 3'd2;
   localparam logic [2:0] PH_DOLLAR  = 3'd3;
   localparam logic [2:0] PH_LEN_DIG = 3'd4;
   localparam logic [2:0] PH_LEN_LF  = 3'd5;
   localparam logic [2:0] PH_DATA    = 3'd6;
   localparam logic [2:0] PH_TRAIL   = 3'd7;

   // result status codes
   localparam logic [2:0] ST_FRAME = 3'd0;
   localparam logic [2:0] ST_DATA  = 3'd1;
   localparam logic [2:0] ST_DONE  = 3'd2;
   localparam logic [2:0] ST_BAD   = 3'd3;
   localparam logic [2:0] ST_CLEAN = 3'd4;
   localparam logic [2:0] ST_TAIL  = 3'd5;

   // input action codes
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_END  = 1'b1;

   // configuration register indexes
   localparam logic CSR_MAX_COUNT = 1'b0;
   localparam logic CSR_MAX_LEN   = 1'b1;

   localparam logic [19:0] MAX_COUNT_RST = 20'd1000000;
   localparam logic [32:0] MAX_LEN_RST   = 33'h1_0000_0000;
   localparam logic [33:0] ACC_MAX       = '1;

   localparam logic [7:0] CHR_STAR   = 8'h2A;
   localparam logic [7:0] CHR_DOLLAR = 8'h24;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_LF     = 8'h0A;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  data_byte;
      logic [19:0] token_index;
      logic        token_last;
      logic [47:0] committed_bytes;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/resp_array_record_parser_unit.sv =====
// RESP array record parser: classifies a byte stream of array records.
// Depends on rarp_pkg and resp_array_record_parser_unit_assert.svh.
// Each result beat is registered when its req beat is accepted, into the skid while rsp stalls.
// Throughput: one beat per cycle while the skid is empty; the parse state takes one pass per byte.
// A two-entry output stage (result register plus skid) keeps req_tready high while
// one result waits. Synchronous active-high reset restores the parse state and
// the register defaults at once; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module resp_array_record_parser_unit #(
   parameter int OFFSET_BITS = 48
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration writes
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [32:0] csr_wdata,
   // input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tuser,   // [0] action
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // [7:0] data_byte, [27:8] token_index,
                                         // [75:28] committed_bytes, [79:76] zero
   output logic [2:0]       rsp_tuser,   // [2:0] status
   output logic             rsp_tlast    // token_last
);

   // configuration registers
   logic [19:0] max_count_ff;
   logic [32:0] max_len_ff;

   // parse state
   logic [2:0]             phase_ff,       phase_in;
   logic [33:0]            acc_ff,         acc_in;
   logic                   seen_ff,        seen_in;
   logic [19:0]            tokens_left_ff, tokens_left_in;
   logic [19:0]            token_pos_ff,   token_pos_in;
   logic [32:0]            bytes_left_ff,  bytes_left_in;
   logic [OFFSET_BITS-1:0] offset_ff,      offset_in;
   logic [OFFSET_BITS-1:0] committed_ff,   committed_in;
   logic                   error_ff,       error_in;

   // output stage
   rarp_pkg::rsp_type res_in;
   rarp_pkg::rsp_type out_ff;
   rarp_pkg::rsp_type skid_ff;
   logic              out_valid_ff;
   logic              skid_valid_ff;

   logic accept;
   logic take_out;

   // working values of the byte step
   logic [7:0]             in_byte;
   logic                   is_digit;
   logic [37:0]            acc_mul;
   logic [33:0]            acc_next;
   logic [19:0]            tokens_dec;
   logic                   bad;

   assign in_byte    = req_tdata;
   assign req_tready = ~skid_valid_ff;
   assign accept     = req_tvalid & req_tready;
   assign take_out   = out_valid_ff & rsp_tready;

   // decimal accumulate: acc * 10 + digit, saturating at all ones
   assign is_digit = (in_byte inside {[8'h30:8'h39]});
   assign acc_mul  = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                     + {34'd0, in_byte[3:0]};
   assign acc_next = (acc_mul[37:34] != 4'd0) ? rarp_pkg::ACC_MAX : acc_mul[33:0];

   assign tokens_dec = (tokens_left_ff == 20'd0) ? 20'd0 : tokens_left_ff - 20'd1;

   // single-pass byte step
   always_comb begin
      phase_in       = phase_ff;
      acc_in         = acc_ff;
      seen_in        = seen_ff;
      tokens_left_in = tokens_left_ff;
      token_pos_in   = token_pos_ff;
      bytes_left_in  = bytes_left_ff;
      offset_in      = offset_ff;
      committed_in   = committed_ff;
      error_in       = error_ff;
      bad            = 1'b0;

      res_in.status      = rarp_pkg::ST_FRAME;
      res_in.data_byte   = 8'd0;
      res_in.token_index = token_pos_ff;
      res_in.token_last  = 1'b0;

      if (error_ff) begin
         res_in.status = rarp_pkg::ST_BAD;
      end else if (req_tuser == rarp_pkg::ACT_END) begin
         // report only; the parse carries on afterwards
         res_in.status = (phase_ff == rarp_pkg::PH_STAR) ? rarp_pkg::ST_CLEAN
                                                         : rarp_pkg::ST_TAIL;
      end else begin
         case (phase_ff)
            rarp_pkg::PH_STAR: begin
               if (in_byte == rarp_pkg::CHR_STAR) begin
                  token_pos_in       = 20'd0;
                  res_in.token_index = 20'd0;
                  acc_in             = 34'd0;
                  seen_in            = 1'b0;
                  phase_in           = rarp_pkg::PH_CNT_DIG;
               end else begin
                  bad = 1'b1;
               end
            end
            rarp_pkg::PH_CNT_DIG, rarp_pkg::PH_LEN_DIG: begin
               if (in_byte == rarp_pkg::CHR_CR) begin
                  phase_in = (phase_ff == rarp_pkg::PH_CNT_DIG) ? rarp_pkg::PH_CNT_LF
                                                                : rarp_pkg::PH_LEN_LF;
               end else if (is_digit) begin
                  seen_in = 1'b1;
                  acc_in  = acc_next;
               end else begin
                  bad = 1'b1;
               end
            end
            rarp_pkg::PH_CNT_LF: begin
               if (in_byte != rarp_pkg::CHR_LF || !seen_ff || acc_ff == 34'd0
                   || acc_ff > {14'd0, max_count_ff}) begin
                  bad = 1'b1;
               end else begin
                  tokens_left_in = acc_ff[19:0];
                  token_pos_in   = 20'd0;
                  phase_in       = rarp_pkg::PH_DOLLAR;
               end
            end
            rarp_pkg::PH_DOLLAR: begin
               if (in_byte == rarp_pkg::CHR_DOLLAR) begin
                  acc_in   = 34'd0;
                  seen_in  = 1'b0;
                  phase_in = rarp_pkg::PH_LEN_DIG;
               end else begin
                  bad = 1'b1;
               end
            end
            rarp_pkg::PH_LEN_LF: begin
               if (in_byte != rarp_pkg::CHR_LF || !seen_ff
                   || acc_ff > {1'b0, max_len_ff}) begin
                  bad = 1'b1;
               end else if (acc_ff == 34'd0) begin
                  // empty token: go straight to the trailer
                  bytes_left_in = 33'd2;
                  phase_in      = rarp_pkg::PH_TRAIL;
               end else begin
                  bytes_left_in = acc_ff[32:0];
                  phase_in      = rarp_pkg::PH_DATA;
               end
            end
            rarp_pkg::PH_DATA: begin
               res_in.status    = rarp_pkg::ST_DATA;
               res_in.data_byte = in_byte;
               if (bytes_left_ff <= 33'd1) begin
                  res_in.token_last = 1'b1;
                  bytes_left_in     = 33'd2;
                  phase_in          = rarp_pkg::PH_TRAIL;
               end else begin
                  bytes_left_in = bytes_left_ff - 33'd1;
               end
            end
            rarp_pkg::PH_TRAIL: begin
               // trailer bytes pass unchecked
               if (bytes_left_ff > 33'd1) begin
                  bytes_left_in = bytes_left_ff - 33'd1;
               end else begin
                  bytes_left_in  = 33'd0;
                  tokens_left_in = tokens_dec;
                  if (tokens_dec == 20'd0) begin
                     res_in.status = rarp_pkg::ST_DONE;
                     committed_in  = offset_ff + 1'b1;
                     phase_in      = rarp_pkg::PH_STAR;
                  end else begin
                     token_pos_in = token_pos_ff + 20'd1;
                     phase_in     = rarp_pkg::PH_DOLLAR;
                  end
               end
            end
            default: begin
               bad = 1'b1;
            end
         endcase

         if (bad) begin
            // sticky: hold the offset from here on
            error_in      = 1'b1;
            res_in.status = rarp_pkg::ST_BAD;
         end else begin
            offset_in = offset_ff + 1'b1;
         end
      end

      // committed offset on the fixed 48-bit result field: zero-extend or truncate
      res_in.committed_bytes = 48'(committed_in);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_count_ff <= rarp_pkg::MAX_COUNT_RST;
         max_len_ff   <= rarp_pkg::MAX_LEN_RST;
      end else if (csr_we) begin
         case (csr_addr)
            rarp_pkg::CSR_MAX_COUNT: max_count_ff <= csr_wdata[19:0];
            rarp_pkg::CSR_MAX_LEN:   max_len_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // parse state: advance on every accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= rarp_pkg::PH_STAR;
         acc_ff         <= '0;
         seen_ff        <= 1'b0;
         tokens_left_ff <= '0;
         token_pos_ff   <= '0;
         bytes_left_ff  <= '0;
         offset_ff      <= '0;
         committed_ff   <= '0;
         error_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         acc_ff         <= acc_in;
         seen_ff        <= seen_in;
         tokens_left_ff <= tokens_left_in;
         token_pos_ff   <= token_pos_in;
         bytes_left_ff  <= bytes_left_in;
         offset_ff      <= offset_in;
         committed_ff   <= committed_in;
         error_ff       <= error_in;
      end
   end

   // output stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff && take_out) begin
         skid_valid_ff <= 1'b0;
      end else if (accept && (!out_valid_ff || take_out)) begin
         out_valid_ff <= 1'b1;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end else if (take_out) begin
         out_valid_ff <= 1'b0;
      end
   end

   // output stage payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff && take_out) begin
         out_ff <= skid_ff;
      end else if (accept && (!out_valid_ff || take_out)) begin
         out_ff <= res_in;
      end else if (accept) begin
         skid_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tlast  = out_ff.token_last;
   assign rsp_tdata  = {4'd0, out_ff.committed_bytes, out_ff.token_index, out_ff.data_byte};

`include "resp_array_record_parser_unit_assert.svh"

   `RARP_ASSERT_IMP(a_skid_behind_out, clock, reset,
                    skid_valid_ff, out_valid_ff,
                    "skid full while result register empty")
   `RARP_ASSERT_NXT(a_error_sticky, clock, reset,
                    error_ff, error_ff,
                    "malformed state cleared")
   `RARP_ASSERT_NXT(a_offset_frozen, clock, reset,
                    error_ff, $stable(offset_ff),
                    "offset moved after malformed")
   `RARP_ASSERT_IMP(a_data_len_nonzero, clock, reset,
                    phase_ff == rarp_pkg::PH_DATA, bytes_left_ff != 33'd0,
                    "data phase with no bytes left")
   `RARP_ASSERT_IMP(a_trail_count, clock, reset,
                    phase_ff == rarp_pkg::PH_TRAIL,
                    bytes_left_ff == 33'd1 || bytes_left_ff == 33'd2,
                    "trailer count out of range")

endmodule

`default_nettype wire

// ===== dv/resp_array_record_parser_unit_tb.sv =====
// Self-checking testbench for resp_array_record_parser_unit: byte beats in, one
// classified result beat out per input beat, checked against an in-bench parser model.
// Depends on rarp_pkg and the RTL of resp_array_record_parser_unit.
`timescale 1ns / 1ps
`default_nettype none

module resp_array_record_parser_unit_tb;

   localparam logic [7:0] CHR_ZERO = 8'h30;
   localparam logic [7:0] CHR_NINE = 8'h39;

   // ways to break the stream, one of which closes the run
   typedef enum int {
      BAD_RECORD_MARKER,
      BAD_TOKEN_MARKER,
      EMPTY_COUNT,
      COUNT_NON_DIGIT,
      COUNT_ZERO,
      COUNT_OVER_LIMIT,
      LEN_OVER_LIMIT,
      CR_WITHOUT_LF,
      COUNT_SATURATED
   } malformed_kind_type;

   typedef struct packed {
      logic       action;
      logic [7:0] in_byte;
   } stream_beat_type;

   // ---------------------------------------------------------------------
   // clock, reset and DUT signals; every input starts from a known value
   // ---------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic        csr_addr   = rarp_pkg::CSR_MAX_COUNT;
   logic [32:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tuser  = rarp_pkg::ACT_BYTE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   always #5 clock = ~clock;

   resp_array_record_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // ---------------------------------------------------------------------
   // parser model: limits and parse state kept at the block's widths
   // ---------------------------------------------------------------------
   logic [19:0] lim_count = rarp_pkg::MAX_COUNT_RST;
   logic [32:0] lim_len   = rarp_pkg::MAX_LEN_RST;

   logic [2:0]  parse_phase   = rarp_pkg::PH_STAR;
   logic [33:0] num_acc       = '0;
   logic        got_digit     = 1'b0;
   logic [19:0] tokens_due    = '0;
   logic [19:0] token_no      = '0;
   logic [32:0] bytes_due     = '0;
   logic [47:0] byte_offset   = '0;
   logic [47:0] commit_offset = '0;
   logic        stream_broken = 1'b0;

   // Advance the model by one accepted input beat and return the result beat
   // that the block owes for it.
   function automatic rarp_pkg::rsp_type classify_beat(logic act, logic [7:0] b);
      rarp_pkg::rsp_type r;
      logic              bad;
      logic [37:0]       acc_next;
      r = '0;
      r.status = rarp_pkg::ST_FRAME;
      r.token_index = token_no;
      bad = 1'b0;
      if (stream_broken) begin
         // malformed is sticky: nothing moves any more
         r.status = rarp_pkg::ST_BAD;
      end else if (act == rarp_pkg::ACT_END) begin
         // end of input only reports; the parse carries on afterwards
         r.status = (parse_phase == rarp_pkg::PH_STAR) ? rarp_pkg::ST_CLEAN
                                                       : rarp_pkg::ST_TAIL;
      end else begin
         case (parse_phase)
            rarp_pkg::PH_STAR: begin
               if (b == rarp_pkg::CHR_STAR) begin
                  token_no = '0;
                  r.token_index = '0;
                  num_acc = '0;
                  got_digit = 1'b0;
                  parse_phase = rarp_pkg::PH_CNT_DIG;
               end else begin
                  bad = 1'b1;
               end
            end
            rarp_pkg::PH_CNT_DIG, rarp_pkg::PH_LEN_DIG: begin
               if (b == rarp_pkg::CHR_CR) begin
                  parse_phase = (parse_phase == rarp_pkg::PH_CNT_DIG)
                                ? rarp_pkg::PH_CNT_LF : rarp_pkg::PH_LEN_LF;
               end else if (b < CHR_ZERO || b > CHR_NINE) begin
                  bad = 1'b1;
               end else begin
                  // saturate so that overlong runs exceed every limit
                  got_digit = 1'b1;
                  acc_next = {4'b0, num_acc} * 38'd10 + {30'b0, b - CHR_ZERO};
                  num_acc = (acc_next > {4'b0, rarp_pkg::ACC_MAX})
                            ? rarp_pkg::ACC_MAX : acc_next[33:0];
               end
            end
            rarp_pkg::PH_CNT_LF: begin
               if (b != rarp_pkg::CHR_LF || !got_digit || num_acc == 0
                   || num_acc > lim_count) begin
                  bad = 1'b1;
               end else begin
                  tokens_due = num_acc[19:0];
                  token_no = '0;
                  parse_phase = rarp_pkg::PH_DOLLAR;
               end
            end
            rarp_pkg::PH_DOLLAR: begin
               if (b == rarp_pkg::CHR_DOLLAR) begin
                  num_acc = '0;
                  got_digit = 1'b0;
                  parse_phase = rarp_pkg::PH_LEN_DIG;
               end else begin
                  bad = 1'b1;
               end
            end
            rarp_pkg::PH_LEN_LF: begin
               if (b != rarp_pkg::CHR_LF || !got_digit || num_acc > lim_len) begin
                  bad = 1'b1;
               end else if (num_acc == 0) begin
                  // empty token: straight on to the trailer
                  bytes_due = 33'd2;
                  parse_phase = rarp_pkg::PH_TRAIL;
               end else begin
                  bytes_due = num_acc[32:0];
                  parse_phase = rarp_pkg::PH_DATA;
               end
            end
            rarp_pkg::PH_DATA: begin
               r.status = rarp_pkg::ST_DATA;
               r.data_byte = b;
               if (bytes_due <= 1) begin
                  r.token_last = 1'b1;
                  bytes_due = 33'd2;
                  parse_phase = rarp_pkg::PH_TRAIL;
               end else begin
                  bytes_due = bytes_due - 1'b1;
               end
            end
            default: begin
               // trailer bytes pass unchecked
               if (bytes_due > 1) begin
                  bytes_due = bytes_due - 1'b1;
               end else begin
                  bytes_due = '0;
                  if (tokens_due != 0) tokens_due = tokens_due - 1'b1;
                  if (tokens_due == 0) begin
                     r.status = rarp_pkg::ST_DONE;
                     commit_offset = byte_offset + 1'b1;
                     parse_phase = rarp_pkg::PH_STAR;
                  end else begin
                     token_no = token_no + 1'b1;
                     parse_phase = rarp_pkg::PH_DOLLAR;
                  end
               end
            end
         endcase
         if (bad) begin
            stream_broken = 1'b1;
            r.status = rarp_pkg::ST_BAD;
         end else begin
            byte_offset = byte_offset + 1'b1;
         end
      end
      r.committed_bytes = commit_offset;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus store and idling controls
   // ---------------------------------------------------------------------
   stream_beat_type   beats_to_send[$];
   rarp_pkg::rsp_type expected_results[$];
   stream_beat_type   next_beat;
   int                beats_queued   = 0;
   int                beats_accepted = 0;
   int                fail_count     = 0;
   int                send_idle_pct  = 0;
   int                recv_idle_pct  = 0;
   int                eoi_noise_pct  = 0;

   // Driver: offer the next pending beat, or idle, once the current one has gone.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_beat = beats_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= next_beat.action;
            req_tdata <= next_beat.in_byte;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stall the result channel at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: predict on every accepted input beat, then check every accepted
   // result beat against the oldest prediction.
   always @(posedge clock) begin
      rarp_pkg::rsp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(classify_beat(req_tuser, req_tdata));
            beats_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result beat: status %0d data %h",
                           rsp_tuser, rsp_tdata[7:0]);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser !== want.status || rsp_tdata[7:0] !== want.data_byte ||
                   rsp_tdata[27:8] !== want.token_index || rsp_tlast !== want.token_last ||
                   rsp_tdata[75:28] !== want.committed_bytes) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch (exp/got): status %0d/%0d data %h/%h index %0d/%0d",
                              want.status, rsp_tuser, want.data_byte, rsp_tdata[7:0],
                              want.token_index, rsp_tdata[27:8]);
                     $display("   last %0b/%0b committed %0d/%0d",
                              want.token_last, rsp_tlast, want.committed_bytes,
                              rsp_tdata[75:28]);
                  end
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_beat(logic act, logic [7:0] b);
      stream_beat_type beat;
      beat.action = act;
      beat.in_byte = b;
      beats_to_send.push_back(beat);
      beats_queued++;
   endtask

   // Queue a stream byte, now and then preceded by a stray end of input.
   task automatic queue_byte(logic [7:0] b);
      if (eoi_noise_pct != 0 && $urandom_range(99) < eoi_noise_pct)
         queue_beat(rarp_pkg::ACT_END, 8'($urandom_range(255)));
      queue_beat(rarp_pkg::ACT_BYTE, b);
   endtask

   task automatic queue_end();
      queue_beat(rarp_pkg::ACT_END, 8'($urandom_range(255)));
   endtask

   // Queue a marker, a decimal number with optional leading zeros, then CR LF.
   task automatic queue_header(logic [7:0] marker, logic [63:0] value, int zeros);
      logic [7:0] digits[$];
      logic [63:0] rest;
      rest = value;
      digits.push_front(CHR_ZERO + 8'(rest % 10));
      rest = rest / 10;
      while (rest != 0) begin
         digits.push_front(CHR_ZERO + 8'(rest % 10));
         rest = rest / 10;
      end
      queue_byte(marker);
      repeat (zeros) queue_byte(CHR_ZERO);
      foreach (digits[i]) queue_byte(digits[i]);
      queue_byte(rarp_pkg::CHR_CR);
      queue_byte(rarp_pkg::CHR_LF);
   endtask

   function automatic int pick_zeros();
      return ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
   endfunction

   // Queue one well-formed record within the current limits; counts and
   // lengths stay small with the odd longer one.
   task automatic queue_record();
      int count_cap;
      int len_cap;
      int n_tok;
      int n_len;
      logic [7:0] d;
      count_cap = (lim_count > 24) ? 24 : int'(lim_count);
      len_cap = (lim_len > 24) ? 24 : int'(lim_len);
      n_tok = ($urandom_range(9) < 8) ? $urandom_range(1, (count_cap < 4) ? count_cap : 4)
                                       : $urandom_range(1, count_cap);
      queue_header(rarp_pkg::CHR_STAR, 64'(n_tok), pick_zeros());
      repeat (n_tok) begin
         n_len = ($urandom_range(9) < 7) ? $urandom_range(0, (len_cap < 6) ? len_cap : 6)
                                          : $urandom_range(0, len_cap);
         queue_header(rarp_pkg::CHR_DOLLAR, 64'(n_len), pick_zeros());
         repeat (n_len) begin
            // framing characters inside data must pass as data
            case ($urandom_range(15))
               0:       d = rarp_pkg::CHR_STAR;
               1:       d = rarp_pkg::CHR_DOLLAR;
               2:       d = rarp_pkg::CHR_CR;
               3:       d = rarp_pkg::CHR_LF;
               default: d = 8'($urandom_range(255));
            endcase
            queue_byte(d);
         end
         queue_byte(8'($urandom_range(255)));
         queue_byte(8'($urandom_range(255)));
      end
   endtask

   // Break the stream once, from a record boundary, then show that it stays broken.
   task automatic queue_malformed(malformed_kind_type kind);
      logic [7:0] b;
      case (kind)
         BAD_RECORD_MARKER: begin
            do b = 8'($urandom_range(255)); while (b == rarp_pkg::CHR_STAR);
            queue_byte(b);
         end
         BAD_TOKEN_MARKER: begin
            queue_header(rarp_pkg::CHR_STAR, 64'd1, 0);
            do b = 8'($urandom_range(255)); while (b == rarp_pkg::CHR_DOLLAR);
            queue_byte(b);
         end
         EMPTY_COUNT: begin
            queue_byte(rarp_pkg::CHR_STAR);
            queue_byte(rarp_pkg::CHR_CR);
            queue_byte(rarp_pkg::CHR_LF);
         end
         COUNT_NON_DIGIT: begin
            queue_byte(rarp_pkg::CHR_STAR);
            queue_byte(CHR_ZERO + 8'd1);
            do b = 8'($urandom_range(255));
            while (b == rarp_pkg::CHR_CR || (b >= CHR_ZERO && b <= CHR_NINE));
            queue_byte(b);
         end
         COUNT_ZERO: queue_header(rarp_pkg::CHR_STAR, 64'd0, pick_zeros());
         COUNT_OVER_LIMIT: queue_header(rarp_pkg::CHR_STAR, {44'b0, lim_count} + 64'd1, 0);
         LEN_OVER_LIMIT: begin
            queue_header(rarp_pkg::CHR_STAR, 64'd1, 0);
            queue_header(rarp_pkg::CHR_DOLLAR, {31'b0, lim_len} + 64'd1, 0);
         end
         CR_WITHOUT_LF: begin
            queue_byte(rarp_pkg::CHR_STAR);
            queue_byte(CHR_ZERO + 8'd1);
            queue_byte(rarp_pkg::CHR_CR);
            do b = 8'($urandom_range(255)); while (b == rarp_pkg::CHR_LF);
            queue_byte(b);
         end
         default: begin
            // twelve nines drive the accumulator into saturation
            queue_byte(rarp_pkg::CHR_STAR);
            repeat (12) queue_byte(CHR_NINE);
            queue_byte(rarp_pkg::CHR_CR);
            queue_byte(rarp_pkg::CHR_LF);
         end
      endcase
      repeat (6) queue_byte(8'($urandom_range(255)));
      queue_end();
      queue_byte(rarp_pkg::CHR_STAR);
   endtask

   task automatic wait_idle();
      while (beats_accepted != beats_queued || expected_results.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Register write; the block is idle, so update the model limits at once.
   task automatic write_reg(logic addr, logic [32:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      if (addr == rarp_pkg::CSR_MAX_COUNT) lim_count = value[19:0];
      else lim_len = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_records(int beats);
      int start;
      start = beats_queued;
      while (beats_queued - start < beats) queue_record();
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset limits: an empty token with extreme trailer bytes,
      // clean end, a tail end inside the record, data bytes at both extremes,
      // and a clean end just after the record.
      send_idle_pct = 34;
      recv_idle_pct = 79;
      queue_header(rarp_pkg::CHR_STAR, 64'd1, 0);
      queue_header(rarp_pkg::CHR_DOLLAR, 64'd0, 0);
      queue_byte(8'hFF);
      queue_byte(8'h00);
      queue_end();
      queue_header(rarp_pkg::CHR_STAR, 64'd1, 0);
      queue_end();
      queue_header(rarp_pkg::CHR_DOLLAR, 64'd2, 0);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(8'h55);
      queue_byte(8'hAA);
      queue_end();
      wait_idle();

      // Widest limits; sender idles lightly, receiver heavily.
      write_reg(rarp_pkg::CSR_MAX_COUNT, 33'h0_000F_FFFF);
      write_reg(rarp_pkg::CSR_MAX_LEN, 33'h1_FFFF_FFFF);
      eoi_noise_pct = 4;
      queue_records(360);
      wait_idle();

      // Tightest limits: single empty tokens only; idling swapped round.
      send_idle_pct = 79;
      recv_idle_pct = 34;
      write_reg(rarp_pkg::CSR_MAX_COUNT, 33'd1);
      write_reg(rarp_pkg::CSR_MAX_LEN, 33'd0);
      queue_records(340);
      wait_idle();

      // Upper bits of the count write must drop, leaving three; no idling.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(rarp_pkg::CSR_MAX_COUNT, 33'h1_FFF0_0003);
      write_reg(rarp_pkg::CSR_MAX_LEN, 33'($urandom_range(1, 12)));
      queue_records(360);
      eoi_noise_pct = 0;
      queue_malformed(malformed_kind_type'($urandom_range(0, 8)));
      wait_idle();
      repeat (10) @(posedge clock);

      if (expected_results.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("resp_array_record_parser_unit_tb: PASS");
      end else begin
         $display("resp_array_record_parser_unit_tb: FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("resp_array_record_parser_unit_tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/rarp_pkg.sv
rtl/resp_array_record_parser_unit.sv
dv/resp_array_record_parser_unit_tb.sv
